// File: rtl/core/fifo_sector_cache_directory_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sector cache directory
// Clocked, reset-qualified implication forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef FIFO_SECTOR_CACHE_DIRECTORY_MACROS_SVH
`define FIFO_SECTOR_CACHE_DIRECTORY_MACROS_SVH

// same-cycle implication
`define FSCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fscd_pkg.sv
// ----------------------------------------------------------------------------
// fscd_pkg
// Types and constants of the FIFO sector cache directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fscd_pkg;

    localparam int ENTRIES      = 64;
    localparam int SECTOR_BYTES = 512;

    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int SECTOR_W = 32;
    localparam int OFFSET_W = 9;
    localparam int SLOT_W   = 6;
    localparam int ADDR_W   = 15;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_FLUSH = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_ACCESS      = 3'd0,
        KIND_FILL        = 3'd1,
        KIND_WRITEBACK   = 3'd2,
        KIND_FREED       = 3'd3,
        KIND_FREE_MISS   = 3'd4,
        KIND_FLUSH_EMPTY = 3'd5
    } t_kind;

    typedef struct packed {
        t_action               action;
        logic [SECTOR_W-1:0]   sector;
        logic [OFFSET_W-1:0]   offset;
        logic                  request_last;
    } t_in_req;

    typedef struct packed {
        t_kind                 kind;
        logic [SECTOR_W-1:0]   target_sector;
        logic [SLOT_W-1:0]     slot;
        logic [ADDR_W-1:0]     byte_address;
        logic                  is_write;
        logic                  end_of_request;
        logic                  last;
    } t_out_res;

    // one directory entry held by a cell
    typedef struct packed {
        logic [SECTOR_W-1:0]   sector;
        logic [SLOT_W-1:0]     slot;
    } t_entry;

    typedef struct packed {
        logic live;        // position below the entry count
        logic take_next;   // shift from the younger neighbor
        logic load;        // load the supplied entry
    } t_cell_ctl;

    typedef struct packed {
        logic                  set;
        logic [SLOT_W-1:0]     set_slot;
        logic                  clr;
        logic [SLOT_W-1:0]     clr_slot;
    } t_map_upd;

endpackage

// File: rtl/core/fscd_cell.sv
// ----------------------------------------------------------------------------
// fscd_cell
// One FIFO position: holds an entry, compares it against the lookup key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fscd_cell import fscd_pkg::*; (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  t_entry              i_next,
    input  t_entry              i_new,
    input  logic [SECTOR_W-1:0] i_key,
    output t_entry              o_entry,
    output logic                o_match
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.take_next) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_match = i_ctl.live && (r_entry.sector == i_key);

endmodule

// File: rtl/core/fscd_slot_map.sv
// ----------------------------------------------------------------------------
// fscd_slot_map
// Slot occupancy bitmap with lowest-free-slot finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fscd_slot_map import fscd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_map_upd          i_upd,
    output logic [SLOT_W-1:0] o_free_slot
);

    logic [ENTRIES-1:0] r_map;
    logic [ENTRIES-1:0] w_inv;
    logic [ENTRIES-1:0] w_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else begin
            if (i_upd.clr) begin
                r_map[i_upd.clr_slot[IDX_W-1:0]] <= 1'b0;
            end
            if (i_upd.set) begin
                r_map[i_upd.set_slot[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // isolate the lowest zero bit, then encode it
    assign w_inv = ~r_map;
    assign w_low = w_inv & (~w_inv + ENTRIES'(1));

    always_comb begin
        o_free_slot = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_low[i]) begin
                o_free_slot = o_free_slot | SLOT_W'(i);
            end
        end
    end

endmodule

// File: rtl/core/fifo_sector_cache_directory.sv
// ----------------------------------------------------------------------------
// fifo_sector_cache_directory
// Fully associative sector cache directory with FIFO replacement, kept in a
// chain of cells ordered oldest first.
//
//   channel  direction  handshake                 payload
//   in       into       i_in_valid / o_in_stall   i_in_req  (t_in_req)
//   out      out of     o_out_valid / i_out_stall o_out_res (t_out_res)
//
// A request is registered and compared in parallel across the cells; then
// its results follow in order: hit an access, miss a fill and an access,
// miss when full a write-back first, free one result, flush a write-back per entry.
// A flush rotates the chain once around, so order is kept.
// Synchronous reset empties the directory at once; no clearing pass.
// Results sit in an output register; new requests are taken while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_sector_cache_directory import fscd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EVICT,
        S_FILL,
        S_ACC,
        S_FREE,
        S_FEMPTY,
        S_FLUSH
    } t_state;

    t_state            r_state;
    t_in_req           r_req;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_left;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [IDX_W-1:0]  r_pos;
    logic              r_out_valid;
    t_out_res          r_out_res;

    t_entry            w_entry [ENTRIES];
    t_entry            w_next  [ENTRIES];
    t_cell_ctl         w_ctl   [ENTRIES];
    logic [ENTRIES-1:0] w_match;
    t_entry            w_load_entry;
    logic [SLOT_W-1:0] w_hit_slot;
    logic [IDX_W-1:0]  w_hit_pos;
    logic [SLOT_W-1:0] w_free_slot;
    t_map_upd          w_upd;
    logic              w_out_free;
    logic              w_emit;
    logic [31:0]       w_addr;
    t_out_res          w_res;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = w_out_free && (r_state != S_IDLE) && (r_state != S_LOOK);

    // ---- cell chain ----
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == ENTRIES - 1) begin : g_tail
            assign w_next[g] = w_entry[g];
        end else begin : g_body
            assign w_next[g] = w_entry[g + 1];
        end

        fscd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_next  (w_next[g]),
            .i_new   (w_load_entry),
            .i_key   (r_req.sector),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // flush rotates the head entry into the tail position
    always_comb begin
        if (r_state == S_FLUSH) begin
            w_load_entry = w_entry[0];
        end else begin
            w_load_entry.sector = r_req.sector;
            w_load_entry.slot   = w_free_slot;
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_ctl[i].live      = CNT_W'(i) < r_count;
            w_ctl[i].take_next = (CNT_W'(i + 1) < r_count) && w_emit &&
                                 ((r_state == S_EVICT) || (r_state == S_FLUSH) ||
                                  ((r_state == S_FREE) && r_hit && (IDX_W'(i) >= r_pos)));
            w_ctl[i].load      = w_emit &&
                                 (((r_state == S_FILL) && (CNT_W'(i) == r_count)) ||
                                  ((r_state == S_FLUSH) && (CNT_W'(i + 1) == r_count)));
        end
    end

    // sectors are unique in the directory, so the match vector has at most one bit set
    always_comb begin
        w_hit_slot = '0;
        w_hit_pos  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_slot = w_hit_slot | w_entry[i].slot;
                w_hit_pos  = w_hit_pos | IDX_W'(i);
            end
        end
    end

    // ---- slot occupancy ----
    always_comb begin
        w_upd.set      = w_emit && (r_state == S_FILL);
        w_upd.set_slot = w_free_slot;
        w_upd.clr      = w_emit && ((r_state == S_EVICT) || ((r_state == S_FREE) && r_hit));
        w_upd.clr_slot = (r_state == S_EVICT) ? w_entry[0].slot : r_slot;
    end

    fscd_slot_map u_slot_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (w_upd),
        .o_free_slot (w_free_slot)
    );

    // ---- result formation ----
    assign w_addr = 32'(r_slot) * 32'(SECTOR_BYTES) +
                    (32'(r_req.offset) % 32'(SECTOR_BYTES));

    always_comb begin
        w_res = '0;
        case (r_state)
            S_EVICT: begin
                w_res.kind          = KIND_WRITEBACK;
                w_res.target_sector = w_entry[0].sector;
                w_res.slot          = w_entry[0].slot;
            end
            S_FILL: begin
                w_res.kind          = KIND_FILL;
                w_res.target_sector = r_req.sector;
                w_res.slot          = w_free_slot;
            end
            S_ACC: begin
                w_res.kind           = KIND_ACCESS;
                w_res.target_sector  = r_req.sector;
                w_res.slot           = r_slot;
                w_res.byte_address   = w_addr[ADDR_W-1:0];
                w_res.is_write       = (r_req.action == ACT_WRITE);
                w_res.end_of_request = r_req.request_last;
                w_res.last           = 1'b1;
            end
            S_FREE: begin
                w_res.kind          = r_hit ? KIND_FREED : KIND_FREE_MISS;
                w_res.target_sector = r_req.sector;
                w_res.slot          = r_hit ? r_slot : '0;
                w_res.last          = 1'b1;
            end
            S_FEMPTY: begin
                w_res.kind = KIND_FLUSH_EMPTY;
                w_res.last = 1'b1;
            end
            S_FLUSH: begin
                w_res.kind          = KIND_WRITEBACK;
                w_res.target_sector = w_entry[0].sector;
                w_res.slot          = w_entry[0].slot;
                w_res.last          = (r_left == CNT_W'(1));
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= w_emit || (r_out_valid && i_out_stall);
            if (w_emit) begin
                r_out_res <= w_res;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_req;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_hit  <= |w_match;
                    r_slot <= w_hit_slot;
                    r_pos  <= w_hit_pos;
                    r_left <= r_count;
                    case (r_req.action)
                        ACT_READ, ACT_WRITE: begin
                            if (|w_match) begin
                                r_state <= S_ACC;
                            end else if (r_count == CNT_W'(ENTRIES)) begin
                                r_state <= S_EVICT;
                            end else begin
                                r_state <= S_FILL;
                            end
                        end
                        ACT_FREE: begin
                            r_state <= S_FREE;
                        end
                        ACT_FLUSH: begin
                            r_state <= (r_count == '0) ? S_FEMPTY : S_FLUSH;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_EVICT: begin
                    if (w_out_free) begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (w_out_free) begin
                        r_count <= r_count + CNT_W'(1);
                        r_slot  <= w_free_slot;
                        r_state <= S_ACC;
                    end
                end
                S_ACC, S_FEMPTY: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FREE: begin
                    if (w_out_free) begin
                        if (r_hit) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_left <= r_left - CNT_W'(1);
                        if (r_left == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

// File: rtl/core/fscd_checker.sv
// ----------------------------------------------------------------------------
// fscd_checker
// Port-level checks on the sector cache directory, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fifo_sector_cache_directory_macros.svh"

module fscd_checker import fscd_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_res o_out_res
);

    logic w_out_held;
    logic w_in_take;
    logic w_closing;
    logic w_fill_shown;
    logic w_fill_ok;

    assign w_out_held   = o_out_valid && i_out_stall;
    assign w_in_take    = i_in_valid && !o_in_stall;
    assign w_closing    = o_out_valid &&
                          ((o_out_res.kind == KIND_ACCESS) ||
                           (o_out_res.kind == KIND_FREED) ||
                           (o_out_res.kind == KIND_FREE_MISS) ||
                           (o_out_res.kind == KIND_FLUSH_EMPTY));
    assign w_fill_shown = o_out_valid && (o_out_res.kind == KIND_FILL);
    assign w_fill_ok    = !o_out_res.last && o_in_stall;

    // a waiting result stays offered
    `FSCD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_held, o_out_valid, "result dropped")

    // an accepted request is looked up before the next one is taken
    `FSCD_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, w_in_take, o_in_stall, "lookup overrun")

    // access, free and empty-flush results always close their request
    `FSCD_ASSERT_IMP(a_final_kinds, i_clk, i_rst_n, w_closing, o_out_res.last, "last missing")

    // a fill is never marked last, since its access follows
    `FSCD_ASSERT_IMP(a_fill_not_last, i_clk, i_rst_n, w_fill_shown, w_fill_ok, "fill marked last")

endmodule

bind fifo_sector_cache_directory fscd_checker u_fscd_checker (.*);

// File: sim/fifo_sector_cache_directory_test.sv
// ----------------------------------------------------------------------------
// fifo_sector_cache_directory_test
// Runs byte accesses, frees and flushes into the sector cache directory and
// predicts the fills, write-backs and byte addresses from its own copy of the
// FIFO directory. Results are compared field by field, in order, while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_sector_cache_directory_test;
    import fscd_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int POOL_SIZE   = 80;
    localparam int RANDOM_REQS = 410;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in_req = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_res o_out_res;

    fifo_sector_cache_directory dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    always #10 i_clk = ~i_clk;

    // shadow directory, oldest entry at position 0
    logic [SECTOR_W-1:0] dir_sector [ENTRIES];
    logic [SLOT_W-1:0]   dir_slot   [ENTRIES];
    int                  dir_count = 0;
    logic [63:0]         slot_busy = '0;

    t_out_res      pending_results [$];
    t_out_res      oldest_pending;
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            burst_left = 0;
    int            stall_mode = 0;
    int            stall_hold = 0;
    logic [31:0]   sector_pool [POOL_SIZE];

    function automatic t_out_res make_result(t_kind k, logic [SECTOR_W-1:0] sec,
                                             logic [SLOT_W-1:0] sl,
                                             logic [ADDR_W-1:0] addr,
                                             logic wr, logic eor);
        t_out_res r;
        r.kind           = k;
        r.target_sector  = sec;
        r.slot           = sl;
        r.byte_address   = addr;
        r.is_write       = wr;
        r.end_of_request = eor;
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic int find_sector(logic [SECTOR_W-1:0] sec);
        for (int i = 0; i < dir_count; i++)
            if (dir_sector[i] == sec) return i;
        return -1;
    endfunction

    // remove one entry, younger ones move up and keep their order
    function automatic void drop_entry(int pos);
        slot_busy[dir_slot[pos]] = 1'b0;
        for (int i = pos; i + 1 < dir_count; i++) begin
            dir_sector[i] = dir_sector[i+1];
            dir_slot[i]   = dir_slot[i+1];
        end
        dir_count--;
    endfunction

    function automatic void predict_directory(t_in_req r);
        int                pos;
        int                addr;
        logic [SLOT_W-1:0] sl;
        sl = '0;
        case (r.action)
            ACT_READ, ACT_WRITE: begin
                pos = find_sector(r.sector);
                if (pos >= 0) begin
                    sl = dir_slot[pos];
                end else begin
                    if (dir_count >= ENTRIES) begin
                        pending_results.push_back(make_result(KIND_WRITEBACK,
                            dir_sector[0], dir_slot[0], '0, 1'b0, 1'b0));
                        drop_entry(0);
                    end
                    for (int s = ENTRIES - 1; s >= 0; s--)
                        if (!slot_busy[s]) sl = SLOT_W'(s);
                    dir_sector[dir_count] = r.sector;
                    dir_slot[dir_count]   = sl;
                    dir_count++;
                    slot_busy[sl] = 1'b1;
                    pending_results.push_back(make_result(KIND_FILL, r.sector, sl,
                                                          '0, 1'b0, 1'b0));
                end
                addr = int'(sl) * SECTOR_BYTES + int'(r.offset) % SECTOR_BYTES;
                pending_results.push_back(make_result(KIND_ACCESS, r.sector, sl,
                    ADDR_W'(addr), r.action == ACT_WRITE, r.request_last));
            end
            ACT_FREE: begin
                pos = find_sector(r.sector);
                if (pos >= 0) begin
                    pending_results.push_back(make_result(KIND_FREED, r.sector,
                        dir_slot[pos], '0, 1'b0, 1'b0));
                    drop_entry(pos);
                end else begin
                    pending_results.push_back(make_result(KIND_FREE_MISS, r.sector,
                        '0, '0, 1'b0, 1'b0));
                end
            end
            default: begin
                if (dir_count == 0)
                    pending_results.push_back(make_result(KIND_FLUSH_EMPTY, '0, '0,
                                                          '0, 1'b0, 1'b0));
                for (int i = 0; i < dir_count; i++)
                    pending_results.push_back(make_result(KIND_WRITEBACK,
                        dir_sector[i], dir_slot[i], '0, 1'b0, 1'b0));
            end
        endcase
        pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(t_action act, logic [SECTOR_W-1:0] sec,
                                logic [OFFSET_W-1:0] off, logic rl);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        i_in_req   = '{act, sec, off, rl};
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_directory(i_in_req);
        @(negedge i_clk);
    endtask

    task automatic test_empty_directory();
        send_request(ACT_FLUSH, '0, '0, 1'b0);
        send_request(ACT_FREE, '0, '0, 1'b0);
        send_request(ACT_READ, '0, '0, 1'b0);
        send_request(ACT_READ, '0, 9'd511, 1'b1);
    endtask

    task automatic test_access_fields();
        send_request(ACT_WRITE, 32'hFFFF_FFFF, 9'd511, 1'b1);
        send_request(ACT_READ, 32'hFFFF_FFFF, 9'd0, 1'b0);
        send_request(ACT_WRITE, 32'hAAAA_AAAA, 9'h155, 1'b0);
        send_request(ACT_READ, 32'h5555_5555, 9'h0AA, 1'b1);
        send_request(ACT_WRITE, 32'h5555_5555, 9'h1FF, 1'b0);
    endtask

    task automatic test_free_and_flush();
        send_request(ACT_FREE, 32'hFFFF_FFFF, '0, 1'b0);   // middle entry
        send_request(ACT_FREE, 32'hFFFF_FFFF, '0, 1'b0);   // now absent
        send_request(ACT_READ, 32'h1234_5678, 9'd300, 1'b1); // reuses freed slot
        send_request(ACT_FLUSH, 32'hDEAD_BEEF, 9'd17, 1'b1);
        send_request(ACT_FREE, '0, '0, 1'b0);               // oldest entry
        send_request(ACT_WRITE, 32'hAAAA_AAAA, 9'd7, 1'b1);
        send_request(ACT_FLUSH, '0, '0, 1'b0);
    endtask

    // fill every slot, then keep missing so the oldest entries get evicted
    task automatic test_full_eviction();
        logic [SECTOR_W-1:0] base;
        base = $urandom & 32'hFFFF_FF00;
        for (int i = 0; i < ENTRIES + 4; i++)
            send_request($urandom_range(0, 1) ? ACT_WRITE : ACT_READ,
                         base + SECTOR_W'(i), OFFSET_W'($urandom),
                         1'($urandom_range(0, 1)));
        send_request(ACT_FLUSH, '0, '0, 1'b0);
        send_request(ACT_FREE, base + 32'd10, '0, 1'b0);
        send_request(ACT_READ, base, 9'd5, 1'b0);
    endtask

    task automatic test_random_traffic(int count);
        int                  pick;
        t_action             act;
        logic [SECTOR_W-1:0] sec;
        for (int i = 0; i < POOL_SIZE; i++) sector_pool[i] = $urandom;
        sector_pool[0] = '0;
        sector_pool[1] = '1;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      act = ACT_READ;
            else if (pick < 75) act = ACT_WRITE;
            else if (pick < 94) act = ACT_FREE;
            else                act = ACT_FLUSH;
            sec = ($urandom_range(0, 9) == 0) ? $urandom
                                              : sector_pool[$urandom_range(0, POOL_SIZE-1)];
            send_request(act, sec, OFFSET_W'($urandom_range(0, 511)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d sector %0h slot %0d",
                       o_out_res.kind, o_out_res.target_sector, o_out_res.slot);
                mismatches++;
            end else begin
                oldest_pending = pending_results.pop_front();
                check_field("kind", oldest_pending.kind, o_out_res.kind);
                check_field("target_sector", oldest_pending.target_sector,
                            o_out_res.target_sector);
                check_field("slot", oldest_pending.slot, o_out_res.slot);
                check_field("byte_address", oldest_pending.byte_address,
                            o_out_res.byte_address);
                check_field("is_write", oldest_pending.is_write, o_out_res.is_write);
                check_field("end_of_request", oldest_pending.end_of_request,
                            o_out_res.end_of_request);
                check_field("last", oldest_pending.last, o_out_res.last);
            end
        end
    end

    // receiver back-pressure: free-flowing, choppy or mostly stalled stretches
    always @(negedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_hold <= $urandom_range(10, 80);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= 1'($urandom_range(0, 1));
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[fifo_sector_cache_directory] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_empty_directory();
        test_access_fields();
        test_free_and_flush();
        test_full_eviction();
        test_random_traffic(RANDOM_REQS);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("[fifo_sector_cache_directory] OK");
        else
            $display("[fifo_sector_cache_directory] ERROR");
        $finish;
    end

endmodule
